// ===== rtl/core/dfscc_pkg.sv =====
// Shared types and constants for the depth-first connected-components block.
package dfscc_pkg;

   // Vertex fields on the ports are four bits wide
   localparam int unsigned VERT_W        = 4;
   localparam int unsigned FIELD_VERTS   = 16;
   localparam int unsigned CFG_W         = 5;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_STEP = 1'b1
   } state_type;

   // Result of the shared lowest-bit search
   typedef struct packed {
      logic              found;
      logic [VERT_W-1:0] index;
   } enc_result_type;

endpackage

// ===== rtl/core/dfscc_lowbit.sv =====
// Shared lowest-set-bit search used for start vertices and neighbor selection.
module dfscc_lowbit #(
   parameter int unsigned WIDTH = 16
) (
   input  logic [WIDTH-1:0]             vec,
   output dfscc_pkg::enc_result_type    result
);

   // Scan from the top so the lowest set bit wins
   always_comb begin
      result.found = 1'b0;
      result.index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (vec[i]) begin
            result.found = 1'b1;
            result.index = dfscc_pkg::VERT_W'(i);
         end
      end
   end

endmodule

// ===== rtl/core/dfs_connected_components.sv =====
// Top level: adjacency matrix, walk stack and traversal sequencer.
// Add-edge and clear items keep busy low, and the next item may follow at once.
// A run item keeps busy high while it steps through n visits plus at most n-1 stack pops.
// Each visit is shown on rsp_* in the cycle after its step, one result per visit, no stall possible.
// The shared lowest-bit search over one adjacency row sets the pace of one step per cycle.
// Synchronous reset clears the matrix, control state and sets vertex_count to 16.
module dfs_connected_components #(
   parameter int unsigned MAX_VERTICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_vertex_a,
   input  logic [3:0]  req_vertex_b,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_visited_vertex,
   output logic [3:0]  rsp_component_index,
   output logic        rsp_is_last,
   output logic [4:0]  rsp_component_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata
);

   localparam int unsigned NV = (MAX_VERTICES < dfscc_pkg::FIELD_VERTS) ?
                                MAX_VERTICES : dfscc_pkg::FIELD_VERTS;
   localparam int unsigned IW = $clog2(NV);
   localparam int unsigned CW = $clog2(NV + 1);

   // State
   logic [NV-1:0]                  adj_ff [NV];
   logic [IW-1:0]                  stack_ff [NV];
   logic [NV-1:0]                  visited_ff, visited_in;
   logic [CW-1:0]                  depth_ff, depth_in;
   logic [CW-1:0]                  comp_ff, comp_in;
   logic [CW-1:0]                  emit_ff, emit_in;
   logic [dfscc_pkg::CFG_W-1:0]    vcount_ff;
   dfscc_pkg::state_type           state_ff, state_in;

   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]                     rsp_vertex_ff, rsp_vertex_in;
   logic [3:0]                     rsp_comp_ff, rsp_comp_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic [4:0]                     rsp_count_ff, rsp_count_in;

   // Datapath
   logic [CW-1:0]                  n_eff;
   logic [NV-1:0]                  used_mask;
   logic                           accept;
   logic                           add_ok;
   logic [CW-1:0]                  depth_m1;
   logic [IW-1:0]                  top_vertex;
   logic [NV-1:0]                  top_row;
   logic [NV-1:0]                  enc_vec;
   dfscc_pkg::enc_result_type      enc;
   logic                           do_visit;
   logic                           do_pop;
   logic                           last_visit;
   logic [CW-1:0]                  emit_next;

   assign accept    = start && !busy;
   assign busy      = (state_ff == dfscc_pkg::ST_STEP);
   assign csr_ready = 1'b1;

   // Clamp the vertex count to the stored matrix size
   assign n_eff = (vcount_ff > dfscc_pkg::CFG_W'(NV)) ? CW'(NV) : vcount_ff[CW-1:0];

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         used_mask[i] = (CW'(i) < n_eff);
      end
   end

   assign add_ok = ({1'b0, req_vertex_a} < dfscc_pkg::CFG_W'(n_eff)) &&
                   ({1'b0, req_vertex_b} < dfscc_pkg::CFG_W'(n_eff));

   // Pick the candidate set: unvisited vertices, or unvisited neighbors of the top
   assign depth_m1   = depth_ff - 1'b1;
   assign top_vertex = stack_ff[depth_m1[IW-1:0]];
   assign top_row    = adj_ff[top_vertex];
   assign enc_vec    = used_mask & ~visited_ff & ((depth_ff == '0) ? '1 : top_row);

   dfscc_lowbit #(
      .WIDTH (NV)
   ) u_lowbit (
      .vec    (enc_vec),
      .result (enc)
   );

   assign do_visit   = busy && enc.found;
   assign do_pop     = busy && !enc.found && (depth_ff != '0);
   assign emit_next  = emit_ff + 1'b1;
   assign last_visit = (emit_next == n_eff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfscc_pkg::ST_IDLE: begin
            if (accept && (req_command == dfscc_pkg::CMD_RUN) && (n_eff != '0)) begin
               state_in = dfscc_pkg::ST_STEP;
            end
         end
         dfscc_pkg::ST_STEP: begin
            if ((do_visit && last_visit) || (!enc.found && (depth_ff == '0))) begin
               state_in = dfscc_pkg::ST_IDLE;
            end
         end
         default: state_in = dfscc_pkg::ST_IDLE;
      endcase
   end

   // Walk bookkeeping and result values
   always_comb begin
      visited_in    = visited_ff;
      depth_in      = depth_ff;
      comp_in       = comp_ff;
      emit_in       = emit_ff;
      rsp_strobe_in = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_last_in   = 1'b0;
      rsp_count_in  = '0;
      if (accept && (req_command == dfscc_pkg::CMD_RUN)) begin
         visited_in = '0;
         depth_in   = '0;
         comp_in    = '0;
         emit_in    = '0;
      end
      if (do_visit) begin
         visited_in    = visited_ff | (NV'(1) << enc.index[IW-1:0]);
         depth_in      = depth_ff + 1'b1;
         emit_in       = emit_next;
         rsp_strobe_in = 1'b1;
         rsp_vertex_in = enc.index;
         rsp_comp_in   = 4'(comp_ff);
         rsp_last_in   = last_visit;
         rsp_count_in  = last_visit ? 5'(CW'(comp_ff + 1'b1)) : '0;
      end
      if (do_pop) begin
         depth_in = depth_m1;
         if (depth_ff == CW'(1)) begin
            comp_in = comp_ff + 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dfscc_pkg::ST_IDLE;
         visited_ff    <= '0;
         depth_ff      <= '0;
         comp_ff       <= '0;
         emit_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_count_ff  <= '0;
         vcount_ff     <= dfscc_pkg::CFG_W'(dfscc_pkg::FIELD_VERTS);
      end else begin
         state_ff      <= state_in;
         visited_ff    <= visited_in;
         depth_ff      <= depth_in;
         comp_ff       <= comp_in;
         emit_ff       <= emit_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_count_ff  <= rsp_count_in;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_wdata;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_comp_ff   <= rsp_comp_in;
   end

   // Adjacency matrix: set both symmetric bits, or clear everything
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NV; r++) begin
            adj_ff[r] <= '0;
         end
      end else if (accept) begin
         case (req_command)
            dfscc_pkg::CMD_ADD: begin
               if (add_ok) begin
                  adj_ff[req_vertex_a[IW-1:0]][req_vertex_b[IW-1:0]] <= 1'b1;
                  adj_ff[req_vertex_b[IW-1:0]][req_vertex_a[IW-1:0]] <= 1'b1;
               end
            end
            dfscc_pkg::CMD_CLEAR: begin
               for (int r = 0; r < NV; r++) begin
                  adj_ff[r] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Walk stack: push the visited vertex on top
   always_ff @(posedge clock) begin
      if (do_visit) begin
         stack_ff[depth_ff[IW-1:0]] <= enc.index[IW-1:0];
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_visited_vertex  = rsp_vertex_ff;
   assign rsp_component_index = rsp_comp_ff;
   assign rsp_is_last         = rsp_last_ff;
   assign rsp_component_count = rsp_count_ff;

`ifndef SYNTH
   // A result only follows a traversal step
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a traversal step");

   // Stack depth stays within the vertex count
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (depth_ff <= n_eff))
      else $error("walk stack deeper than vertex count");

   // Never emit more vertices than are in use
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (emit_ff < n_eff))
      else $error("visit count overran vertex count");

   // The final result ends the run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_last) |-> !busy)
      else $error("last result while traversal continues");

   // Component count only appears on the last result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_component_count != '0) |-> (rsp_strobe && rsp_is_last))
      else $error("component count outside the last result");
`endif

endmodule
